// ----- rtl/dg2_face_record_validator_unit_defines.svh -----
// Assertion macros used by the face record validator parser.
// Included by the parser, which checks its own control logic.
`ifndef DG2_FACE_RECORD_VALIDATOR_UNIT_DEFINES_SVH
`define DG2_FACE_RECORD_VALIDATOR_UNIT_DEFINES_SVH
`define DG2_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define DG2_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ----- rtl/dg2frv_pkg.sv -----
// Types and constants for the DG2 face record validator.
// No dependencies.
package dg2frv_pkg;
   localparam logic [5:0] PH_T75 = 6'd0, PH_T7F_A = 6'd1, PH_T61 = 6'd2, PH_T02 = 6'd3,
      PH_INST = 6'd4, PH_T7F_B = 6'd5, PH_T60 = 6'd6, PH_TA1 = 6'd7, PH_CB_TAG = 6'd8,
      PH_CB_VAL = 6'd9, PH_CB_SKIP = 6'd10, PH_T5F = 6'd11, PH_T2E = 6'd12,
      PH_FAC = 6'd13, PH_VER = 6'd14, PH_RLEN = 6'd15, PH_NIMG = 6'd16,
      PH_NFEAT = 6'd17, PH_FATTR = 6'd18, PH_FSKIP = 6'd19, PH_FTYPE = 6'd20,
      PH_ITYPE = 6'd21, PH_DIM = 6'd22, PH_IINFO = 6'd23, PH_SIG = 6'd24,
      PH_DONE = 6'd25, PH_ERR = 6'd26, PH_LEN1 = 6'd27, PH_LENX = 6'd28;
   localparam logic [2:0] LC_75 = 3'd0, LC_7F61 = 3'd1, LC_INST = 3'd2, LC_7F60 = 3'd3,
      LC_A1 = 3'd4, LC_CB = 3'd5, LC_5F2E = 3'd6;
   localparam logic [4:0] ERR_NONE = 5'd0, ERR_TRUNC = 5'd1, ERR_TAG = 5'd2,
      ERR_LFORM = 5'd3, ERR_INST = 5'd4, ERR_PATRON = 5'd5, ERR_BTYPE = 5'd6,
      ERR_OWNER = 5'd7, ERR_FTYPE = 5'd8, ERR_MISSING = 5'd9, ERR_FMTID = 5'd10,
      ERR_VER = 5'd11, ERR_RLEN = 5'd12, ERR_NIMG = 5'd13, ERR_FRONTAL = 5'd14,
      ERR_IMGTYPE = 5'd15, ERR_DIM = 5'd16, ERR_SIG = 5'd17, ERR_HDR = 5'd18;
   localparam logic [1:0] CSR_WIDTH_MIN = 2'd0, CSR_WIDTH_MAX = 2'd1,
      CSR_HEIGHT_MIN = 2'd2, CSR_HEIGHT_MAX = 2'd3;
   localparam logic [63:0] JP2_SIGNATURE = 64'h0000000C6A502020;
   localparam logic [31:0] FAC_ID = 32'h46414300;
   localparam logic [31:0] VER_ID = 32'h30313000;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        valid_res;
      logic [4:0]  error_code;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic [31:0] image_offset;
      logic [31:0] image_length;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  index;
      logic [15:0] data;
   } csr_type;

   typedef struct packed {
      logic [15:0] width_min;
      logic [15:0] width_max;
      logic [15:0] height_min;
      logic [15:0] height_max;
   } limits_type;
endpackage

// ----- rtl/dg2frv_req_if.sv -----
// Request channel interface (valid/ready) for the DG2 face record validator.
// Depends on dg2frv_pkg.
interface dg2frv_req_if;
   logic                valid;
   logic                ready;
   dg2frv_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/dg2frv_rsp_if.sv -----
// Result channel interface for the DG2 face record validator.
// Depends on dg2frv_pkg.
interface dg2frv_rsp_if;
   logic                valid;
   logic                ready;
   dg2frv_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/dg2frv_csr_if.sv -----
// Register write channel interface for the DG2 face record validator.
// Depends on dg2frv_pkg.
interface dg2frv_csr_if;
   logic                valid;
   logic                ready;
   dg2frv_pkg::csr_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/dg2frv_regs.sv -----
// Limit registers written through the register channel.
// Depends on dg2frv_pkg.
module dg2frv_regs (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  dg2frv_pkg::csr_type    wr,
   output dg2frv_pkg::limits_type limits
);
   dg2frv_pkg::limits_type lim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff.width_min  <= 16'd240;
         lim_ff.width_max  <= 16'd1024;
         lim_ff.height_min <= 16'd320;
         lim_ff.height_max <= 16'd1024;
      end else if (wr_en && wr.index[7:2] == 6'd0) begin
         unique case (wr.index[1:0])
            dg2frv_pkg::CSR_WIDTH_MIN:  lim_ff.width_min  <= wr.data;
            dg2frv_pkg::CSR_WIDTH_MAX:  lim_ff.width_max  <= wr.data;
            dg2frv_pkg::CSR_HEIGHT_MIN: lim_ff.height_min <= wr.data;
            default:                    lim_ff.height_max <= wr.data;
         endcase
      end
   end

   assign limits = lim_ff;
endmodule

// ----- rtl/dg2frv_parser.sv -----
// Byte parser: walks the TLV frame and face record, one byte per step.
// Depends on dg2frv_pkg and the assertion macro header.
`include "dg2_face_record_validator_unit_defines.svh"
module dg2frv_parser #(
   parameter int SIGNATURE_SPAN    = 20,
   parameter int MAX_LENGTH_OCTETS = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  dg2frv_pkg::req_type    req,
   input  dg2frv_pkg::limits_type limits,
   output dg2frv_pkg::rsp_type    verdict
);
   localparam int WinW = $clog2(SIGNATURE_SPAN + 8);
   localparam logic [WinW-1:0] WinEnd = WinW'(SIGNATURE_SPAN + 7);
   localparam logic [WinW-1:0] WinMin = WinW'(8);

   logic [5:0]  phase_ff, phase_in;
   logic [2:0]  ctx_ff, ctx_in;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] acc_ff, acc_in;
   logic [2:0]  oct_ff, oct_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [32:0] hend_ff, hend_in;
   logic [3:0]  seen_ff, seen_in;
   logic [7:0]  tag_ff, tag_in;
   logic [7:0]  hold_ff, hold_in;
   logic [31:0] rlen_ff, rlen_in;
   logic [31:0] rstart_ff, rstart_in;
   logic [31:0] skip_ff, skip_in;
   logic [15:0] wid_ff, wid_in;
   logic [15:0] hgt_ff, hgt_in;
   logic [63:0] win_ff, win_in;
   logic [WinW-1:0] woc_ff, woc_in;
   logic [4:0]  err_ff, err_in;
   logic [31:0] ioff_ff, ioff_in;
   logic [31:0] ilen_ff, ilen_in;

   logic [7:0]  b;
   logic [31:0] after;
   logic        ld_go;
   logic [31:0] ld_len;
   logic        cbn_go;
   logic [3:0]  cbn_seen;
   logic [4:0]  fail_code;
   logic        fail_go;
   logic [31:0] acc_sh;
   logic [31:0] hdr;
   logic [15:0] cbv;
   logic        cb_need2;
   logic [63:0] win_sh;
   logic [WinW-1:0] woc_inc;
   logic [5:0]  ph;
   logic [4:0]  code;
   logic [6:0]  lform;

   always_comb begin
      b = req.data_byte;
      after = pos_ff + 32'd1;
      acc_sh = {acc_ff[23:0], b};
      hdr = after - rstart_ff;
      win_sh = {win_ff[55:0], b};
      woc_inc = woc_ff + WinW'(1);
      cb_need2 = (tag_ff != 8'h81);
      cbv = cb_need2 ? {hold_ff, b} : {8'h00, b};
      lform = b[6:0];

      phase_in = phase_ff; ctx_in = ctx_ff; pos_in = after; acc_in = acc_ff;
      oct_in = oct_ff; cnt_in = cnt_ff; hend_in = hend_ff; seen_in = seen_ff;
      tag_in = tag_ff; hold_in = hold_ff; rlen_in = rlen_ff; rstart_in = rstart_ff;
      skip_in = skip_ff; wid_in = wid_ff; hgt_in = hgt_ff; win_in = win_ff;
      woc_in = woc_ff; err_in = err_ff; ioff_in = ioff_ff; ilen_in = ilen_ff;
      ld_go = 1'b0; ld_len = 32'd0; cbn_go = 1'b0; cbn_seen = seen_ff;
      fail_go = 1'b0; fail_code = dg2frv_pkg::ERR_NONE;

      unique case (phase_ff)
         dg2frv_pkg::PH_T75: begin
            if (b != 8'h75) begin fail_go = 1'b1; fail_code = dg2frv_pkg::ERR_TAG; end
            else begin ctx_in = dg2frv_pkg::LC_75; phase_in = dg2frv_pkg::PH_LEN1; end
         end
         dg2frv_pkg::PH_T7F_A, dg2frv_pkg::PH_T7F_B: begin
            if (b != 8'h7F) begin fail_go = 1'b1; fail_code = dg2frv_pkg::ERR_TAG; end
            else phase_in = phase_ff + 6'd1;
         end
         dg2frv_pkg::PH_T61: begin
            if (b != 8'h61) begin fail_go = 1'b1; fail_code = dg2frv_pkg::ERR_TAG; end
            else begin ctx_in = dg2frv_pkg::LC_7F61; phase_in = dg2frv_pkg::PH_LEN1; end
         end
         dg2frv_pkg::PH_T02: begin
            if (b != 8'h02) begin fail_go = 1'b1; fail_code = dg2frv_pkg::ERR_TAG; end
            else begin ctx_in = dg2frv_pkg::LC_INST; phase_in = dg2frv_pkg::PH_LEN1; end
         end
         dg2frv_pkg::PH_INST: begin
            if (b != 8'h01) begin fail_go = 1'b1; fail_code = dg2frv_pkg::ERR_INST; end
            else phase_in = dg2frv_pkg::PH_T7F_B;
         end
         dg2frv_pkg::PH_T60: begin
            if (b != 8'h60) begin fail_go = 1'b1; fail_code = dg2frv_pkg::ERR_TAG; end
            else begin ctx_in = dg2frv_pkg::LC_7F60; phase_in = dg2frv_pkg::PH_LEN1; end
         end
         dg2frv_pkg::PH_TA1: begin
            if (b != 8'hA1) begin fail_go = 1'b1; fail_code = dg2frv_pkg::ERR_TAG; end
            else begin ctx_in = dg2frv_pkg::LC_A1; phase_in = dg2frv_pkg::PH_LEN1; end
         end
         dg2frv_pkg::PH_CB_TAG: begin
            tag_in = b; ctx_in = dg2frv_pkg::LC_CB; phase_in = dg2frv_pkg::PH_LEN1;
         end
         dg2frv_pkg::PH_CB_VAL: begin
            if (cnt_ff == 4'd0) hold_in = b;
            cnt_in = cnt_ff + 4'd1;
            if (!cb_need2 || cnt_ff != 4'd0) begin
               priority case (tag_ff)
                  8'h80: if (cbv != 16'h0101) begin
                     fail_go = 1'b1; fail_code = dg2frv_pkg::ERR_PATRON;
                  end else begin cbn_go = 1'b1; cbn_seen = seen_ff | 4'b0001; end
                  8'h81: if (cbv != 16'h0002) begin
                     fail_go = 1'b1; fail_code = dg2frv_pkg::ERR_BTYPE;
                  end else begin cbn_go = 1'b1; cbn_seen = seen_ff | 4'b0010; end
                  8'h87: if (cbv != 16'h0101) begin
                     fail_go = 1'b1; fail_code = dg2frv_pkg::ERR_OWNER;
                  end else begin cbn_go = 1'b1; cbn_seen = seen_ff | 4'b0100; end
                  default: if (cbv != 16'h0008) begin
                     fail_go = 1'b1; fail_code = dg2frv_pkg::ERR_FTYPE;
                  end else begin cbn_go = 1'b1; cbn_seen = seen_ff | 4'b1000; end
               endcase
            end
         end
         dg2frv_pkg::PH_CB_SKIP: begin
            skip_in = skip_ff - 32'd1;
            if (skip_ff == 32'd1) cbn_go = 1'b1;
         end
         dg2frv_pkg::PH_T5F: begin
            if (b != 8'h5F) begin fail_go = 1'b1; fail_code = dg2frv_pkg::ERR_TAG; end
            else phase_in = dg2frv_pkg::PH_T2E;
         end
         dg2frv_pkg::PH_T2E: begin
            if (b != 8'h2E) begin fail_go = 1'b1; fail_code = dg2frv_pkg::ERR_TAG; end
            else begin ctx_in = dg2frv_pkg::LC_5F2E; phase_in = dg2frv_pkg::PH_LEN1; end
         end
         dg2frv_pkg::PH_FAC, dg2frv_pkg::PH_VER: begin
            if ((phase_ff == dg2frv_pkg::PH_FAC &&
                 b != dg2frv_pkg::FAC_ID[8*(3-cnt_ff[1:0]) +: 8]) ||
                (phase_ff == dg2frv_pkg::PH_VER &&
                 b != dg2frv_pkg::VER_ID[8*(3-cnt_ff[1:0]) +: 8])) begin
               fail_go = 1'b1;
               fail_code = (phase_ff == dg2frv_pkg::PH_FAC) ? dg2frv_pkg::ERR_FMTID
                                                            : dg2frv_pkg::ERR_VER;
            end else begin
               cnt_in = cnt_ff + 4'd1;
               if (cnt_ff == 4'd3) begin
                  cnt_in = 4'd0;
                  if (phase_ff == dg2frv_pkg::PH_FAC) phase_in = dg2frv_pkg::PH_VER;
                  else begin acc_in = 32'd0; phase_in = dg2frv_pkg::PH_RLEN; end
               end
            end
         end
         dg2frv_pkg::PH_RLEN: begin
            acc_in = acc_sh; cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd3) begin
               if (acc_sh != rlen_ff) begin fail_go = 1'b1; fail_code = dg2frv_pkg::ERR_RLEN; end
               else begin cnt_in = 4'd0; acc_in = 32'd0; phase_in = dg2frv_pkg::PH_NIMG; end
            end
         end
         dg2frv_pkg::PH_NIMG: begin
            acc_in = acc_sh; cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd1) begin
               if (acc_sh != 32'd1) begin fail_go = 1'b1; fail_code = dg2frv_pkg::ERR_NIMG; end
               else begin cnt_in = 4'd0; acc_in = 32'd0; phase_in = dg2frv_pkg::PH_NFEAT; end
            end
         end
         dg2frv_pkg::PH_NFEAT: begin
            acc_in = acc_sh; cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd1) begin
               skip_in = {13'd0, acc_sh[15:0], 3'd0};
               cnt_in = 4'd0; phase_in = dg2frv_pkg::PH_FATTR;
            end
         end
         dg2frv_pkg::PH_FATTR: begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd13)
               phase_in = (skip_ff == 32'd0) ? dg2frv_pkg::PH_FTYPE : dg2frv_pkg::PH_FSKIP;
         end
         dg2frv_pkg::PH_FSKIP: begin
            skip_in = skip_ff - 32'd1;
            if (skip_ff == 32'd1) phase_in = dg2frv_pkg::PH_FTYPE;
         end
         dg2frv_pkg::PH_FTYPE: begin
            if (b != 8'h01) begin fail_go = 1'b1; fail_code = dg2frv_pkg::ERR_FRONTAL; end
            else phase_in = dg2frv_pkg::PH_ITYPE;
         end
         dg2frv_pkg::PH_ITYPE: begin
            if (b != 8'h02) begin fail_go = 1'b1; fail_code = dg2frv_pkg::ERR_IMGTYPE; end
            else begin cnt_in = 4'd0; phase_in = dg2frv_pkg::PH_DIM; end
         end
         dg2frv_pkg::PH_DIM: begin
            priority case (cnt_ff)
               4'd0: wid_in = {b, 8'h00};
               4'd1: wid_in = {wid_ff[15:8], b};
               4'd2: hgt_in = {b, 8'h00};
               default: hgt_in = {hgt_ff[15:8], b};
            endcase
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd3) begin
               if (wid_ff < limits.width_min || wid_ff > limits.width_max ||
                   {hgt_ff[15:8], b} < limits.height_min ||
                   {hgt_ff[15:8], b} > limits.height_max) begin
                  fail_go = 1'b1; fail_code = dg2frv_pkg::ERR_DIM;
               end else begin cnt_in = 4'd0; phase_in = dg2frv_pkg::PH_IINFO; end
            end
         end
         dg2frv_pkg::PH_IINFO: begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd3) begin
               if (hdr > rlen_ff) begin fail_go = 1'b1; fail_code = dg2frv_pkg::ERR_HDR; end
               else begin
                  ioff_in = after; ilen_in = rlen_ff - hdr;
                  win_in = 64'd0; woc_in = '0; phase_in = dg2frv_pkg::PH_SIG;
               end
            end
         end
         dg2frv_pkg::PH_SIG: begin
            win_in = win_sh; woc_in = woc_inc;
            if (woc_inc >= WinMin && win_sh == dg2frv_pkg::JP2_SIGNATURE)
               phase_in = dg2frv_pkg::PH_DONE;
            else if (woc_inc >= WinEnd) begin
               fail_go = 1'b1; fail_code = dg2frv_pkg::ERR_SIG;
            end
         end
         dg2frv_pkg::PH_LEN1: begin
            if (!b[7]) begin ld_go = 1'b1; ld_len = {24'd0, b}; end
            else if (lform == 7'd0 || lform > 7'(MAX_LENGTH_OCTETS)) begin
               fail_go = 1'b1; fail_code = dg2frv_pkg::ERR_LFORM;
            end else begin
               oct_in = lform[2:0]; acc_in = 32'd0; phase_in = dg2frv_pkg::PH_LENX;
            end
         end
         dg2frv_pkg::PH_LENX: begin
            acc_in = acc_sh; oct_in = oct_ff - 3'd1;
            if (oct_ff == 3'd1) begin ld_go = 1'b1; ld_len = acc_sh; end
         end
         default: ;
      endcase

      if (ld_go) begin
         unique case (ctx_ff)
            dg2frv_pkg::LC_75:   phase_in = dg2frv_pkg::PH_T7F_A;
            dg2frv_pkg::LC_7F61: phase_in = dg2frv_pkg::PH_T02;
            dg2frv_pkg::LC_INST: begin
               if (ld_len != 32'd1) begin fail_go = 1'b1; fail_code = dg2frv_pkg::ERR_INST; end
               else phase_in = dg2frv_pkg::PH_INST;
            end
            dg2frv_pkg::LC_7F60: phase_in = dg2frv_pkg::PH_TA1;
            dg2frv_pkg::LC_A1: begin
               hend_in = {1'b0, after} + {1'b0, ld_len};
               cbn_seen = 4'd0; cbn_go = 1'b1;
            end
            dg2frv_pkg::LC_CB: begin
               cnt_in = 4'd0;
               priority case (tag_ff)
                  8'h80: if (ld_len != 32'd2) begin
                     fail_go = 1'b1; fail_code = dg2frv_pkg::ERR_PATRON;
                  end else phase_in = dg2frv_pkg::PH_CB_VAL;
                  8'h81: if (ld_len != 32'd1) begin
                     fail_go = 1'b1; fail_code = dg2frv_pkg::ERR_BTYPE;
                  end else phase_in = dg2frv_pkg::PH_CB_VAL;
                  8'h87: if (ld_len != 32'd2) begin
                     fail_go = 1'b1; fail_code = dg2frv_pkg::ERR_OWNER;
                  end else phase_in = dg2frv_pkg::PH_CB_VAL;
                  8'h88: if (ld_len != 32'd2) begin
                     fail_go = 1'b1; fail_code = dg2frv_pkg::ERR_FTYPE;
                  end else phase_in = dg2frv_pkg::PH_CB_VAL;
                  default: begin
                     skip_in = ld_len;
                     if (ld_len == 32'd0) cbn_go = 1'b1;
                     else phase_in = dg2frv_pkg::PH_CB_SKIP;
                  end
               endcase
            end
            default: begin
               rlen_in = ld_len; rstart_in = after; cnt_in = 4'd0;
               phase_in = dg2frv_pkg::PH_FAC;
            end
         endcase
      end

      if (cbn_go) begin
         seen_in = cbn_seen;
         if ({1'b0, after} < hend_in) phase_in = dg2frv_pkg::PH_CB_TAG;
         else if (cbn_seen != 4'hF) begin
            fail_go = 1'b1; fail_code = dg2frv_pkg::ERR_MISSING;
         end else phase_in = dg2frv_pkg::PH_T5F;
      end

      if (fail_go) begin
         if (err_ff == dg2frv_pkg::ERR_NONE) err_in = fail_code;
         phase_in = dg2frv_pkg::PH_ERR;
      end

      ph = phase_in;
      if (err_in != dg2frv_pkg::ERR_NONE) code = err_in;
      else if (ph == dg2frv_pkg::PH_DONE) code = dg2frv_pkg::ERR_NONE;
      else if (ph == dg2frv_pkg::PH_SIG) code = dg2frv_pkg::ERR_SIG;
      else code = dg2frv_pkg::ERR_TRUNC;
      verdict.valid_res = (code == dg2frv_pkg::ERR_NONE);
      verdict.error_code = code;
      verdict.image_width = wid_in;
      verdict.image_height = hgt_in;
      verdict.image_offset = ioff_in;
      verdict.image_length = ilen_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && req.last_byte)) begin
         phase_ff <= dg2frv_pkg::PH_T75; ctx_ff <= dg2frv_pkg::LC_75; pos_ff <= '0;
         acc_ff <= '0; oct_ff <= '0; cnt_ff <= '0; hend_ff <= '0; seen_ff <= '0;
         tag_ff <= '0; hold_ff <= '0; rlen_ff <= '0; rstart_ff <= '0; skip_ff <= '0;
         wid_ff <= '0; hgt_ff <= '0; win_ff <= '0; woc_ff <= '0; err_ff <= '0;
         ioff_ff <= '0; ilen_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in; ctx_ff <= ctx_in; pos_ff <= pos_in; acc_ff <= acc_in;
         oct_ff <= oct_in; cnt_ff <= cnt_in; hend_ff <= hend_in; seen_ff <= seen_in;
         tag_ff <= tag_in; hold_ff <= hold_in; rlen_ff <= rlen_in; rstart_ff <= rstart_in;
         skip_ff <= skip_in; wid_ff <= wid_in; hgt_ff <= hgt_in; win_ff <= win_in;
         woc_ff <= woc_in; err_ff <= err_in; ioff_ff <= ioff_in; ilen_ff <= ilen_in;
      end
   end

   `DG2_ASSERT_IMPL(a_err_phase, clock, reset, err_ff != dg2frv_pkg::ERR_NONE,
      phase_ff == dg2frv_pkg::PH_ERR)
   `DG2_ASSERT_IMPL(a_err_range, clock, reset, 1'b1, err_ff <= dg2frv_pkg::ERR_HDR)
   `DG2_ASSERT_NEXT(a_restart, clock, reset, step && req.last_byte,
      phase_ff == dg2frv_pkg::PH_T75 && pos_ff == 32'd0)
endmodule

// ----- rtl/dg2_face_record_validator_unit.sv -----
// Channel | Dir | Payload
// req     | in  | data_byte[7:0], last_byte
// rsp     | out | valid_res, error_code[4:0], image_width/height, image_offset/length
// csr     | in  | index[7:0], data[15:0] (0 width_min .. 3 height_max)
// One byte per cycle while input is not stalled; each byte is parsed in the cycle it is accepted and the
// verdict for a last byte lands in the output register on that edge.
// A full output register stalls input only when it is not being drained.
// Synchronous reset restores the limit defaults and restarts the parser.
module dg2_face_record_validator_unit #(
   parameter int SIGNATURE_SPAN    = 20,
   parameter int MAX_LENGTH_OCTETS = 4
) (
   input logic clock,
   input logic reset,
   dg2frv_req_if.sink   req,
   dg2frv_rsp_if.source rsp,
   dg2frv_csr_if.sink   csr
);
   dg2frv_pkg::limits_type limits;
   dg2frv_pkg::rsp_type    verdict;
   dg2frv_pkg::rsp_type    rsp_ff;
   logic                   rsp_valid_ff;
   logic                   step;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign step = req.valid && req.ready;
   assign csr.ready = 1'b1;

   dg2frv_regs u_regs (
      .clock(clock), .reset(reset), .wr_en(csr.valid), .wr(csr.payload), .limits(limits)
   );

   dg2frv_parser #(
      .SIGNATURE_SPAN(SIGNATURE_SPAN), .MAX_LENGTH_OCTETS(MAX_LENGTH_OCTETS)
   ) u_parser (
      .clock(clock), .reset(reset), .step(step), .req(req.payload),
      .limits(limits), .verdict(verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (step && req.payload.last_byte) rsp_valid_ff <= 1'b1;
      else if (rsp.ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (step && req.payload.last_byte) rsp_ff <= verdict;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;
endmodule

// ----- verif/tb_dg2_face_record_validator_unit.sv -----
// Self-checking testbench for dg2_face_record_validator_unit: streams DG2 objects byte
// by byte and checks each verdict against a cycle-free parser model here or a typed error code.
// Depends on dg2frv_pkg and the req, rsp and csr channel interfaces.
module tb_dg2_face_record_validator_unit;
   localparam int SIG_SPAN      = 20;
   localparam int MAX_OCTETS    = 4;
   localparam int IDLE_LIMIT    = 4000;
   localparam int PHASE_ITEMS   = 120;
   localparam logic [7:0] TAG_PATRON = 8'h80, TAG_BTYPE = 8'h81, TAG_OWNER = 8'h87,
      TAG_FTYPE = 8'h88;
   localparam int OBJ_CLEAN = 0, OBJ_FLIPPED = 1, OBJ_CUT = 2, OBJ_SHORT_REC = 3,
      OBJ_NOISE = 4;

   typedef struct {
      dg2frv_pkg::req_type item;
      bit                  typed;
      logic [4:0]          typed_code;
   } stim_type;

   logic clock;
   logic reset;
   dg2frv_req_if req ();
   dg2frv_rsp_if rsp ();
   dg2frv_csr_if csr ();

   dg2_face_record_validator_unit u_top (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source),
      .csr(csr.sink)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // parser model state
   logic [5:0]  parse_state;
   logic [2:0]  len_owner;
   logic [31:0] byte_pos, len_acc, rec_len, rec_start, skip_left, img_off, img_len;
   logic [7:0]  octs_left, fld_cnt, cb_tag, held, win_cnt;
   logic [32:0] hdr_end;
   logic [3:0]  seen;
   logic [15:0] wid, hgt;
   logic [63:0] sig_win;
   logic [4:0]  first_err;
   dg2frv_pkg::limits_type lim;

   dg2frv_pkg::rsp_type verdict_q[$];
   stim_type            stim_q[$];
   int       mismatches = 0;
   int       idle_cycles = 0;
   int       stall_left = 0;
   int       cycle_cnt = 0;

   task clear_parser;
      parse_state = dg2frv_pkg::PH_T75; len_owner = dg2frv_pkg::LC_75;
      byte_pos = '0; len_acc = '0; octs_left = '0; fld_cnt = '0; hdr_end = '0;
      seen = '0; cb_tag = '0; held = '0; rec_len = '0; rec_start = '0; skip_left = '0;
      wid = '0; hgt = '0; sig_win = '0; win_cnt = '0; first_err = dg2frv_pkg::ERR_NONE;
      img_off = '0; img_len = '0;
   endtask

   task latch_err(input logic [4:0] code);
      if (first_err == dg2frv_pkg::ERR_NONE) first_err = code;
      parse_state = dg2frv_pkg::PH_ERR;
   endtask

   task next_cbeff(input logic [31:0] after);
      if ({1'b0, after} < hdr_end) parse_state = dg2frv_pkg::PH_CB_TAG;
      else if (seen != 4'hF) latch_err(dg2frv_pkg::ERR_MISSING);
      else parse_state = dg2frv_pkg::PH_T5F;
   endtask

   task close_length(input logic [31:0] len, input logic [31:0] after);
      case (len_owner)
         dg2frv_pkg::LC_75: parse_state = dg2frv_pkg::PH_T7F_A;
         dg2frv_pkg::LC_7F61: parse_state = dg2frv_pkg::PH_T02;
         dg2frv_pkg::LC_INST:
            if (len != 32'd1) latch_err(dg2frv_pkg::ERR_INST);
            else parse_state = dg2frv_pkg::PH_INST;
         dg2frv_pkg::LC_7F60: parse_state = dg2frv_pkg::PH_TA1;
         dg2frv_pkg::LC_A1: begin
            hdr_end = {1'b0, after} + {1'b0, len};
            seen = '0;
            next_cbeff(after);
         end
         dg2frv_pkg::LC_CB: begin
            fld_cnt = '0;
            case (cb_tag)
               TAG_PATRON: if (len != 32'd2) latch_err(dg2frv_pkg::ERR_PATRON);
                           else parse_state = dg2frv_pkg::PH_CB_VAL;
               TAG_BTYPE: if (len != 32'd1) latch_err(dg2frv_pkg::ERR_BTYPE);
                          else parse_state = dg2frv_pkg::PH_CB_VAL;
               TAG_OWNER: if (len != 32'd2) latch_err(dg2frv_pkg::ERR_OWNER);
                          else parse_state = dg2frv_pkg::PH_CB_VAL;
               TAG_FTYPE: if (len != 32'd2) latch_err(dg2frv_pkg::ERR_FTYPE);
                          else parse_state = dg2frv_pkg::PH_CB_VAL;
               default: begin
                  skip_left = len;
                  if (len == 32'd0) next_cbeff(after);
                  else parse_state = dg2frv_pkg::PH_CB_SKIP;
               end
            endcase
         end
         default: begin
            rec_len = len; rec_start = after; fld_cnt = '0;
            parse_state = dg2frv_pkg::PH_FAC;
         end
      endcase
   endtask

   task take_cbeff_value(input logic [7:0] b, input logic [31:0] after);
      logic [7:0]  need;
      logic [15:0] v;
      need = (cb_tag == TAG_BTYPE) ? 8'd1 : 8'd2;
      if (fld_cnt == 8'd0) held = b;
      fld_cnt = fld_cnt + 8'd1;
      if (fld_cnt >= need) begin
         v = (need == 8'd2) ? {held, b} : {8'h00, b};
         case (cb_tag)
            TAG_PATRON: if (v != 16'h0101) latch_err(dg2frv_pkg::ERR_PATRON);
                        else seen[0] = 1'b1;
            TAG_BTYPE: if (v != 16'h0002) latch_err(dg2frv_pkg::ERR_BTYPE);
                       else seen[1] = 1'b1;
            TAG_OWNER: if (v != 16'h0101) latch_err(dg2frv_pkg::ERR_OWNER);
                       else seen[2] = 1'b1;
            default: if (v != 16'h0008) latch_err(dg2frv_pkg::ERR_FTYPE);
                     else seen[3] = 1'b1;
         endcase
         if (parse_state != dg2frv_pkg::PH_ERR) next_cbeff(after);
      end
   endtask

   task advance_parser(input dg2frv_pkg::req_type it, output bit has,
                       output dg2frv_pkg::rsp_type r);
      logic [7:0]  b;
      logic [31:0] after, hdr;
      logic [4:0]  code;
      b = it.data_byte;
      after = byte_pos + 32'd1;
      case (parse_state)
         dg2frv_pkg::PH_T75:
            if (b != 8'h75) latch_err(dg2frv_pkg::ERR_TAG);
            else begin len_owner = dg2frv_pkg::LC_75; parse_state = dg2frv_pkg::PH_LEN1; end
         dg2frv_pkg::PH_T7F_A:
            if (b != 8'h7F) latch_err(dg2frv_pkg::ERR_TAG);
            else parse_state = dg2frv_pkg::PH_T61;
         dg2frv_pkg::PH_T61:
            if (b != 8'h61) latch_err(dg2frv_pkg::ERR_TAG);
            else begin len_owner = dg2frv_pkg::LC_7F61; parse_state = dg2frv_pkg::PH_LEN1; end
         dg2frv_pkg::PH_T02:
            if (b != 8'h02) latch_err(dg2frv_pkg::ERR_TAG);
            else begin len_owner = dg2frv_pkg::LC_INST; parse_state = dg2frv_pkg::PH_LEN1; end
         dg2frv_pkg::PH_INST:
            if (b != 8'h01) latch_err(dg2frv_pkg::ERR_INST);
            else parse_state = dg2frv_pkg::PH_T7F_B;
         dg2frv_pkg::PH_T7F_B:
            if (b != 8'h7F) latch_err(dg2frv_pkg::ERR_TAG);
            else parse_state = dg2frv_pkg::PH_T60;
         dg2frv_pkg::PH_T60:
            if (b != 8'h60) latch_err(dg2frv_pkg::ERR_TAG);
            else begin len_owner = dg2frv_pkg::LC_7F60; parse_state = dg2frv_pkg::PH_LEN1; end
         dg2frv_pkg::PH_TA1:
            if (b != 8'hA1) latch_err(dg2frv_pkg::ERR_TAG);
            else begin len_owner = dg2frv_pkg::LC_A1; parse_state = dg2frv_pkg::PH_LEN1; end
         dg2frv_pkg::PH_CB_TAG: begin
            cb_tag = b; len_owner = dg2frv_pkg::LC_CB; parse_state = dg2frv_pkg::PH_LEN1;
         end
         dg2frv_pkg::PH_CB_VAL: take_cbeff_value(b, after);
         dg2frv_pkg::PH_CB_SKIP: begin
            skip_left = skip_left - 32'd1;
            if (skip_left == 32'd0) next_cbeff(after);
         end
         dg2frv_pkg::PH_T5F:
            if (b != 8'h5F) latch_err(dg2frv_pkg::ERR_TAG);
            else parse_state = dg2frv_pkg::PH_T2E;
         dg2frv_pkg::PH_T2E:
            if (b != 8'h2E) latch_err(dg2frv_pkg::ERR_TAG);
            else begin len_owner = dg2frv_pkg::LC_5F2E; parse_state = dg2frv_pkg::PH_LEN1; end
         dg2frv_pkg::PH_FAC: begin
            if (b != dg2frv_pkg::FAC_ID[31 - 8 * fld_cnt[1:0] -: 8])
               latch_err(dg2frv_pkg::ERR_FMTID);
            else begin
               fld_cnt = fld_cnt + 8'd1;
               if (fld_cnt == 8'd4) begin
                  fld_cnt = '0; parse_state = dg2frv_pkg::PH_VER;
               end
            end
         end
         dg2frv_pkg::PH_VER: begin
            if (b != dg2frv_pkg::VER_ID[31 - 8 * fld_cnt[1:0] -: 8])
               latch_err(dg2frv_pkg::ERR_VER);
            else begin
               fld_cnt = fld_cnt + 8'd1;
               if (fld_cnt == 8'd4) begin
                  fld_cnt = '0; len_acc = '0; parse_state = dg2frv_pkg::PH_RLEN;
               end
            end
         end
         dg2frv_pkg::PH_RLEN: begin
            len_acc = {len_acc[23:0], b};
            fld_cnt = fld_cnt + 8'd1;
            if (fld_cnt == 8'd4) begin
               if (len_acc != rec_len) latch_err(dg2frv_pkg::ERR_RLEN);
               else begin fld_cnt = '0; len_acc = '0; parse_state = dg2frv_pkg::PH_NIMG; end
            end
         end
         dg2frv_pkg::PH_NIMG: begin
            len_acc = {len_acc[23:0], b};
            fld_cnt = fld_cnt + 8'd1;
            if (fld_cnt == 8'd2) begin
               if (len_acc != 32'd1) latch_err(dg2frv_pkg::ERR_NIMG);
               else begin fld_cnt = '0; len_acc = '0; parse_state = dg2frv_pkg::PH_NFEAT; end
            end
         end
         dg2frv_pkg::PH_NFEAT: begin
            len_acc = {len_acc[23:0], b};
            fld_cnt = fld_cnt + 8'd1;
            if (fld_cnt == 8'd2) begin
               skip_left = {13'd0, len_acc[15:0], 3'd0};
               fld_cnt = '0; parse_state = dg2frv_pkg::PH_FATTR;
            end
         end
         dg2frv_pkg::PH_FATTR: begin
            fld_cnt = fld_cnt + 8'd1;
            if (fld_cnt == 8'd14)
               parse_state = (skip_left == 32'd0) ? dg2frv_pkg::PH_FTYPE
                                                  : dg2frv_pkg::PH_FSKIP;
         end
         dg2frv_pkg::PH_FSKIP: begin
            skip_left = skip_left - 32'd1;
            if (skip_left == 32'd0) parse_state = dg2frv_pkg::PH_FTYPE;
         end
         dg2frv_pkg::PH_FTYPE:
            if (b != 8'h01) latch_err(dg2frv_pkg::ERR_FRONTAL);
            else parse_state = dg2frv_pkg::PH_ITYPE;
         dg2frv_pkg::PH_ITYPE:
            if (b != 8'h02) latch_err(dg2frv_pkg::ERR_IMGTYPE);
            else begin fld_cnt = '0; parse_state = dg2frv_pkg::PH_DIM; end
         dg2frv_pkg::PH_DIM: begin
            case (fld_cnt)
               8'd0: wid = {b, 8'h00};
               8'd1: wid = {wid[15:8], b};
               8'd2: hgt = {b, 8'h00};
               default: hgt = {hgt[15:8], b};
            endcase
            fld_cnt = fld_cnt + 8'd1;
            if (fld_cnt == 8'd4) begin
               if (wid < lim.width_min || wid > lim.width_max ||
                   hgt < lim.height_min || hgt > lim.height_max)
                  latch_err(dg2frv_pkg::ERR_DIM);
               else begin fld_cnt = '0; parse_state = dg2frv_pkg::PH_IINFO; end
            end
         end
         dg2frv_pkg::PH_IINFO: begin
            fld_cnt = fld_cnt + 8'd1;
            if (fld_cnt == 8'd4) begin
               hdr = after - rec_start;
               if (hdr > rec_len) latch_err(dg2frv_pkg::ERR_HDR);
               else begin
                  img_off = after; img_len = rec_len - hdr;
                  sig_win = '0; win_cnt = '0; parse_state = dg2frv_pkg::PH_SIG;
               end
            end
         end
         dg2frv_pkg::PH_SIG: begin
            sig_win = {sig_win[55:0], b};
            if (win_cnt < 8'd255) win_cnt = win_cnt + 8'd1;
            if (win_cnt >= 8'd8 && sig_win == dg2frv_pkg::JP2_SIGNATURE)
               parse_state = dg2frv_pkg::PH_DONE;
            else if (win_cnt >= 8'(SIG_SPAN + 7)) latch_err(dg2frv_pkg::ERR_SIG);
         end
         dg2frv_pkg::PH_LEN1: begin
            if (b < 8'h80) close_length({24'd0, b}, after);
            else begin
               octs_left = {1'b0, b[6:0]};
               if (octs_left == 8'd0 || octs_left > 8'(MAX_OCTETS))
                  latch_err(dg2frv_pkg::ERR_LFORM);
               else begin len_acc = '0; parse_state = dg2frv_pkg::PH_LENX; end
            end
         end
         dg2frv_pkg::PH_LENX: begin
            len_acc = {len_acc[23:0], b};
            octs_left = octs_left - 8'd1;
            if (octs_left == 8'd0) close_length(len_acc, after);
         end
         default: ;
      endcase
      byte_pos = after;
      has = it.last_byte;
      r = '0;
      if (has) begin
         if (first_err != dg2frv_pkg::ERR_NONE) code = first_err;
         else if (parse_state == dg2frv_pkg::PH_DONE) code = dg2frv_pkg::ERR_NONE;
         else if (parse_state == dg2frv_pkg::PH_SIG) code = dg2frv_pkg::ERR_SIG;
         else code = dg2frv_pkg::ERR_TRUNC;
         r.valid_res = (code == dg2frv_pkg::ERR_NONE);
         r.error_code = code;
         r.image_width = wid;
         r.image_height = hgt;
         r.image_offset = img_off;
         r.image_length = img_len;
         clear_parser();
      end
   endtask

   task flag_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch on %s: got %0h, expected %0h", what, got, want);
      mismatches++;
   endtask

   // result side: stall pattern, checking and watchdog
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (stall_left != 0) begin
         rsp.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp.ready <= 1'b1;
         if (cycle_cnt[9:8] != 2'd0 && $urandom_range(0, 3) == 0)
            stall_left <= $urandom_range(1, 7);
      end
   end

   always @(negedge clock) begin
      dg2frv_pkg::rsp_type want;
      if (!reset) begin
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (csr.valid && csr.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
         if (rsp.valid === 1'b1 && rsp.ready) begin
            if (verdict_q.size() == 0) begin
               flag_mismatch("unexpected verdict, error_code",
                             32'(rsp.payload.error_code), 32'd0);
            end else begin
               want = verdict_q.pop_front();
               if (rsp.payload.valid_res !== want.valid_res)
                  flag_mismatch("valid_res", 32'(rsp.payload.valid_res),
                                32'(want.valid_res));
               if (rsp.payload.error_code !== want.error_code)
                  flag_mismatch("error_code", 32'(rsp.payload.error_code),
                                32'(want.error_code));
               if (rsp.payload.image_width !== want.image_width)
                  flag_mismatch("image_width", 32'(rsp.payload.image_width),
                                32'(want.image_width));
               if (rsp.payload.image_height !== want.image_height)
                  flag_mismatch("image_height", 32'(rsp.payload.image_height),
                                32'(want.image_height));
               if (rsp.payload.image_offset !== want.image_offset)
                  flag_mismatch("image_offset", rsp.payload.image_offset, want.image_offset);
               if (rsp.payload.image_length !== want.image_length)
                  flag_mismatch("image_length", rsp.payload.image_length, want.image_length);
            end
         end
      end
   end

   // stimulus building
   task automatic put_len(ref bit [7:0] q[$], input int unsigned len);
      int n;
      if (len < 128 && $urandom_range(0, 1) == 1) q.push_back(len[7:0]);
      else begin
         n = (len < 256) ? 1 : (len < 65536) ? 2 : (len < 32'h0100_0000) ? 3 : 4;
         n = n + int'($urandom_range(0, MAX_OCTETS - n));
         q.push_back(8'h80 | n[7:0]);
         for (int i = n - 1; i >= 0; i--) q.push_back(8'(len >> (8 * i)));
      end
   endtask

   task automatic queue_bytes(ref bit [7:0] q[$]);
      stim_type s;
      for (int i = 0; i < q.size(); i++) begin
         s.item.data_byte = q[i];
         s.item.last_byte = (i == q.size() - 1);
         s.typed = 1'b0;
         s.typed_code = dg2frv_pkg::ERR_NONE;
         stim_q.push_back(s);
      end
   endtask

   task automatic build_object(input int kind, input logic [15:0] w, input logic [15:0] h);
      bit [7:0] cb[$], rec[$], mid[$], obj[$];
      int ord[];
      int k, j, t, n, nfeat, pad;
      int unsigned rl;
      if (kind == OBJ_NOISE) begin
         n = $urandom_range(1, 30);
         for (int i = 0; i < n; i++) obj.push_back(8'($urandom_range(0, 255)));
         queue_bytes(obj);
         return;
      end
      k = 4 + (($urandom_range(0, 2) == 0) ? int'($urandom_range(1, 2)) : 0);
      ord = new[k];
      for (int i = 0; i < k; i++) ord[i] = i;
      for (int i = k - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = ord[i]; ord[i] = ord[j]; ord[j] = t;
      end
      foreach (ord[i]) begin
         case (ord[i])
            0: begin
               cb.push_back(TAG_PATRON); put_len(cb, 2);
               cb.push_back(8'd1); cb.push_back(8'd1);
            end
            1: begin cb.push_back(TAG_BTYPE); put_len(cb, 1); cb.push_back(8'd2); end
            2: begin
               cb.push_back(TAG_OWNER); put_len(cb, 2);
               cb.push_back(8'd1); cb.push_back(8'd1);
            end
            3: begin
               cb.push_back(TAG_FTYPE); put_len(cb, 2);
               cb.push_back(8'd0); cb.push_back(8'd8);
            end
            default: begin
               do t = $urandom_range(0, 255);
               while (t == TAG_PATRON || t == TAG_BTYPE || t == TAG_OWNER || t == TAG_FTYPE);
               cb.push_back(8'(t));
               n = $urandom_range(0, 4);
               put_len(cb, n);
               for (int i = 0; i < n; i++) cb.push_back(8'($urandom_range(0, 255)));
            end
         endcase
      end
      for (int i = 0; i < 4; i++) rec.push_back(dg2frv_pkg::FAC_ID[31 - 8 * i -: 8]);
      for (int i = 0; i < 4; i++) rec.push_back(dg2frv_pkg::VER_ID[31 - 8 * i -: 8]);
      repeat (4) rec.push_back(8'd0);
      rec.push_back(8'd0); rec.push_back(8'd1);
      nfeat = ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 3)) : 0;
      rec.push_back(8'd0); rec.push_back(8'(nfeat));
      repeat (14 + 8 * nfeat) rec.push_back(8'($urandom_range(0, 255)));
      rec.push_back(8'd1); rec.push_back(8'd2);
      rec.push_back(w[15:8]); rec.push_back(w[7:0]);
      rec.push_back(h[15:8]); rec.push_back(h[7:0]);
      repeat (4) rec.push_back(8'($urandom_range(0, 255)));
      pad = ($urandom_range(0, 5) == 0) ? int'($urandom_range(13, 24))
                                         : int'($urandom_range(0, 12));
      repeat (pad) rec.push_back(8'($urandom_range(0, 255)));
      for (int i = 0; i < 8; i++)
         rec.push_back(dg2frv_pkg::JP2_SIGNATURE[63 - 8 * i -: 8]);
      repeat ($urandom_range(0, 5)) rec.push_back(8'($urandom_range(0, 255)));
      rl = (kind == OBJ_SHORT_REC) ? $urandom_range(0, 35) : int'(rec.size());
      for (int i = 0; i < 4; i++) rec[8 + i] = 8'(rl >> (24 - 8 * i));
      mid.push_back(8'hA1); put_len(mid, cb.size());
      foreach (cb[i]) mid.push_back(cb[i]);
      mid.push_back(8'h5F); mid.push_back(8'h2E); put_len(mid, rl);
      foreach (rec[i]) mid.push_back(rec[i]);
      obj.push_back(8'h75);
      put_len(obj, ($urandom_range(0, 1) == 1) ? $urandom : mid.size() + 10);
      obj.push_back(8'h7F); obj.push_back(8'h61); put_len(obj, mid.size() + 7);
      obj.push_back(8'h02); put_len(obj, 1); obj.push_back(8'h01);
      obj.push_back(8'h7F); obj.push_back(8'h60); put_len(obj, mid.size());
      foreach (mid[i]) obj.push_back(mid[i]);
      if (kind == OBJ_FLIPPED)
         obj[$urandom_range(0, obj.size() - 1)] = 8'($urandom_range(0, 255));
      if (kind == OBJ_CUT) obj = obj[0 : $urandom_range(0, obj.size() - 2)];
      queue_bytes(obj);
   endtask

   function automatic logic [15:0] pick_dim(input logic [15:0] lo, input logic [15:0] hi);
      if (lo <= hi && $urandom_range(0, 4) != 0) return 16'($urandom_range(lo, hi));
      return 16'($urandom_range(0, 65535));
   endfunction

   // input side
   int burst_left = 0;

   task send_stim(input stim_type s);
      bit                  has;
      dg2frv_pkg::rsp_type r;
      req.valid <= 1'b1;
      req.payload <= s.item;
      forever begin
         @(negedge clock);
         if (req.ready) begin
            @(posedge clock);
            break;
         end
         @(posedge clock);
      end
      advance_parser(s.item, has, r);
      if (has) begin
         if (s.typed) begin
            r = '0;
            r.error_code = s.typed_code;
            r.valid_res = (s.typed_code == dg2frv_pkg::ERR_NONE);
         end
         verdict_q.push_back(r);
      end
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 2) != 0) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end else burst_left--;
   endtask

   task send_all;
      while (stim_q.size() != 0) send_stim(stim_q.pop_front());
      req.valid <= 1'b0;
      @(posedge clock);
   endtask

   task settle;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task write_limit(input logic [1:0] idx, input logic [15:0] value);
      csr.valid <= 1'b1;
      csr.payload <= '{index: {6'd0, idx}, data: value};
      forever begin
         @(negedge clock);
         if (csr.ready) begin
            @(posedge clock);
            break;
         end
         @(posedge clock);
      end
      case (idx)
         dg2frv_pkg::CSR_WIDTH_MIN: lim.width_min = value;
         dg2frv_pkg::CSR_WIDTH_MAX: lim.width_max = value;
         dg2frv_pkg::CSR_HEIGHT_MIN: lim.height_min = value;
         default: lim.height_max = value;
      endcase
      csr.valid <= 1'b0;
      @(posedge clock);
   endtask

   task set_limits(input logic [15:0] wmin, wmax, hmin, hmax);
      write_limit(dg2frv_pkg::CSR_WIDTH_MIN, wmin);
      write_limit(dg2frv_pkg::CSR_WIDTH_MAX, wmax);
      write_limit(dg2frv_pkg::CSR_HEIGHT_MIN, hmin);
      write_limit(dg2frv_pkg::CSR_HEIGHT_MAX, hmax);
   endtask

   typedef struct {
      logic [7:0] data;
      bit         last;
      bit         typed;
      logic [4:0] code;
   } row_type;

   row_type short_rows[] = '{
      '{8'h00, 1, 1, dg2frv_pkg::ERR_TAG},
      '{8'hFF, 1, 1, dg2frv_pkg::ERR_TAG},
      '{8'h75, 1, 1, dg2frv_pkg::ERR_TRUNC},
      '{8'h75, 0, 0, dg2frv_pkg::ERR_NONE}, '{8'h80, 1, 1, dg2frv_pkg::ERR_LFORM},
      '{8'h75, 0, 0, dg2frv_pkg::ERR_NONE}, '{8'h85, 1, 1, dg2frv_pkg::ERR_LFORM},
      '{8'h75, 0, 0, dg2frv_pkg::ERR_NONE}, '{8'h84, 0, 0, dg2frv_pkg::ERR_NONE},
      '{8'hFF, 0, 0, dg2frv_pkg::ERR_NONE}, '{8'hFF, 0, 0, dg2frv_pkg::ERR_NONE},
      '{8'hFF, 0, 0, dg2frv_pkg::ERR_NONE}, '{8'hFF, 1, 1, dg2frv_pkg::ERR_TRUNC},
      '{8'h75, 0, 0, dg2frv_pkg::ERR_NONE}, '{8'h00, 0, 0, dg2frv_pkg::ERR_NONE},
      '{8'h7E, 1, 1, dg2frv_pkg::ERR_TAG},
      '{8'h75, 0, 0, dg2frv_pkg::ERR_NONE}, '{8'h00, 0, 0, dg2frv_pkg::ERR_NONE},
      '{8'h7F, 0, 0, dg2frv_pkg::ERR_NONE}, '{8'h61, 0, 0, dg2frv_pkg::ERR_NONE},
      '{8'h00, 0, 0, dg2frv_pkg::ERR_NONE}, '{8'h02, 0, 0, dg2frv_pkg::ERR_NONE},
      '{8'h02, 1, 1, dg2frv_pkg::ERR_INST}
   };

   initial begin
      stim_type s;
      int       sent, r;
      reset = 1'b1;
      req.valid <= 1'b0;
      req.payload <= '0;
      csr.valid <= 1'b0;
      csr.payload <= '0;
      lim = '{width_min: 16'd240, width_max: 16'd1024, height_min: 16'd320,
              height_max: 16'd1024};
      clear_parser();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (short_rows[i]) begin
         s.item.data_byte = short_rows[i].data;
         s.item.last_byte = short_rows[i].last;
         s.typed = short_rows[i].typed;
         s.typed_code = short_rows[i].code;
         stim_q.push_back(s);
      end
      build_object(OBJ_CLEAN, 16'd240, 16'd1024);
      build_object(OBJ_CLEAN, 16'd1024, 16'd320);
      build_object(OBJ_CLEAN, 16'd239, 16'd500);
      build_object(OBJ_CLEAN, 16'd500, 16'd1025);
      build_object(OBJ_SHORT_REC, 16'd500, 16'd500);
      send_all();

      for (int ph = 0; ph < 6; ph++) begin
         settle();
         case (ph)
            0: set_limits(16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
            1: set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            2: set_limits(16'd0, 16'd0, 16'd0, 16'd0);
            3: set_limits(16'($urandom_range(0, 400)), 16'($urandom_range(400, 65535)),
                          16'($urandom_range(0, 400)), 16'($urandom_range(400, 65535)));
            4: set_limits(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                          16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            default: set_limits(16'd240, 16'd1024, 16'd320, 16'd1024);
         endcase
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            build_object(r < 55 ? OBJ_CLEAN : r < 78 ? OBJ_FLIPPED : r < 90 ? OBJ_CUT :
                         r < 95 ? OBJ_SHORT_REC : OBJ_NOISE,
                         pick_dim(lim.width_min, lim.width_max),
                         pick_dim(lim.height_min, lim.height_max));
            sent += stim_q.size();
            send_all();
         end
      end

      settle();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && verdict_q.size() == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule
